### design/bad_pkg.sv
// ----------------------------------------------------------------------------
// Box average downscaler package
// Shared types and constants for the box average downscaler.
// ----------------------------------------------------------------------------
package bad_pkg;

    localparam int CHAN_W = 8;
    localparam int SUM_W  = 32;
    localparam int CNT_W  = 25;
    localparam int CFG_W  = 13;
    localparam int POS_W  = 12;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH  = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
        logic [CNT_W-1:0] count;
    } pixel_sums_t;

endpackage

### design/bad_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module bad_divider #(
    parameter int NW = 32,
    parameter int DW = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int SW = $clog2(NW + 1);

    logic [SW-1:0] step_reg, step_next;
    logic          done_reg, done_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   rem_shift;

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_shift = {rem_reg, quo_reg[NW-1]};
        if (start)
        begin
            step_next = SW'(NW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (step_reg != '0)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = DW'(rem_shift - {1'b0, dvs_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = DW'(rem_shift);
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == SW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### design/bad_sum_ram.sv
// ----------------------------------------------------------------------------
// Column sum memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module bad_sum_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  bad_pkg::pixel_sums_t wdata,
    input  logic [AW-1:0]        raddr,
    output bad_pkg::pixel_sums_t rdata
);

    import bad_pkg::*;

    pixel_sums_t mem [DEPTH];
    pixel_sums_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/box_average_downscaler_core.sv
// ----------------------------------------------------------------------------
// Box average downscaler core
// Accumulates source pixels into per-column sums and emits box averages.
// ----------------------------------------------------------------------------
// A pixel without result goes through the memory read, then the write back.
// A pixel that closes a box goes through the read and write back, the 32-step
// divider and its done flag, the hold state (longer while an earlier
// result is stalled in the output register), then idle.
// After reset and after every register write a clearing pass over all
// MAX_WIDTH entries zeroes the sum memory; the first pixel is taken after it.
// ----------------------------------------------------------------------------
module box_average_downscaler_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [bad_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [23:0]               s_axis_tdata,   // in_blue, in_green, in_red
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_blue, out_green, out_red, out_alpha, out_column, out_row
    output logic [55:0]               m_axis_tdata,
    output logic                      m_axis_tlast    // frame_last
);

    import bad_pkg::*;

    localparam int CW = (MAX_WIDTH > 8191) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int RW = (MAX_HEIGHT > 8191) ? CFG_W : $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int AH = $clog2(MAX_HEIGHT);
    localparam int WX = ((AW > CW) ? AW : CW) + 1;
    localparam int WY = ((AH > RW) ? AH : RW) + 1;

    typedef enum logic [4:0] {
        ST_INIT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_RMW  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [CW-1:0] sw, tw;
    logic [RW-1:0] sh, th;

    logic          setup_start_reg;
    logic          w_done_reg, h_done_reg;
    logic          clr_done_reg;
    logic [AW-1:0] clr_reg;
    logic          dw_done, dh_done;
    logic [CW-1:0] qw, rw;
    logic [RW-1:0] qh, rh;

    logic [CW-1:0] src_col_reg, src_col_next;
    logic [RW-1:0] src_row_reg, src_row_next;
    logic [AW-1:0] dst_col_reg, dst_col_next;
    logic [AH-1:0] dst_row_reg, dst_row_next;
    logic [CW-1:0] col_end_reg, col_end_next, col_rem_reg, col_rem_next;
    logic [RW-1:0] row_end_reg, row_end_next, row_rem_reg, row_rem_next;

    logic [CHAN_W-1:0] pix_b_reg, pix_g_reg, pix_r_reg;
    logic              emit_reg, last_reg;
    logic [AW-1:0]     col_reg;
    logic [AH-1:0]     row_reg;

    logic              col_hit, row_hit, accept, cfg_ok;
    logic [CW:0]       col_sum;
    logic [RW:0]       row_sum;
    logic [RW-1:0]     row_inc;

    pixel_sums_t rdata, wdata, acc;
    logic        we;
    logic [AW-1:0] waddr;

    logic        div_start;
    logic        div_done_b, div_done_g, div_done_r;
    logic [SUM_W-1:0] quo_b, quo_g, quo_r;
    logic [CNT_W-1:0] rem_b, rem_g, rem_r;
    logic        zero_cnt_reg;

    logic             out_valid_reg;
    logic [55:0]      out_data_reg;
    logic             out_last_reg;

    assign cfg_ok = cfg_write;
    assign accept = (state_reg == ST_IDLE) && s_axis_tvalid;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        if (src_w_reg == '0)
            sw = CW'(1);
        else if (32'(src_w_reg) > 32'(MAX_WIDTH))
            sw = CW'(MAX_WIDTH);
        else
            sw = CW'(src_w_reg);
        if (dst_w_reg == '0)
            tw = CW'(1);
        else if (32'(dst_w_reg) > 32'(sw))
            tw = sw;
        else
            tw = CW'(dst_w_reg);
        if (src_h_reg == '0)
            sh = RW'(1);
        else if (32'(src_h_reg) > 32'(MAX_HEIGHT))
            sh = RW'(MAX_HEIGHT);
        else
            sh = RW'(src_h_reg);
        if (dst_h_reg == '0)
            th = RW'(1);
        else if (32'(dst_h_reg) > 32'(sh))
            th = sh;
        else
            th = RW'(dst_h_reg);
    end

    bad_divider #(.NW(CW), .DW(CW)) u_div_w (
        .clk(clk), .rst_n(rst_n), .start(setup_start_reg),
        .dividend(sw), .divisor(tw), .done(dw_done),
        .quotient(qw), .remainder(rw)
    );

    bad_divider #(.NW(RW), .DW(RW)) u_div_h (
        .clk(clk), .rst_n(rst_n), .start(setup_start_reg),
        .dividend(sh), .divisor(th), .done(dh_done),
        .quotient(qh), .remainder(rh)
    );

    assign col_hit = ({1'b0, src_col_reg} + 1'b1) >= {1'b0, col_end_reg};
    assign row_hit = ({1'b0, src_row_reg} + 1'b1) >= {1'b0, row_end_reg};
    assign col_sum = {1'b0, col_rem_reg} + {1'b0, rw};
    assign row_sum = {1'b0, row_rem_reg} + {1'b0, rh};
    assign row_inc = src_row_reg + 1'b1;

    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        dst_col_next = dst_col_reg;
        dst_row_next = dst_row_reg;
        col_end_next = col_end_reg;
        col_rem_next = col_rem_reg;
        row_end_next = row_end_reg;
        row_rem_next = row_rem_reg;
        if (col_hit)
        begin
            if ((WX'(dst_col_reg) + 1'b1) >= WX'(tw))
            begin
                dst_col_next = '0;
                col_end_next = qw;
                col_rem_next = rw;
            end
            else
            begin
                dst_col_next = dst_col_reg + 1'b1;
                if (col_sum >= {1'b0, tw})
                begin
                    col_rem_next = CW'(col_sum - {1'b0, tw});
                    col_end_next = col_end_reg + qw + 1'b1;
                end
                else
                begin
                    col_rem_next = CW'(col_sum);
                    col_end_next = col_end_reg + qw;
                end
            end
        end
        src_col_next = src_col_reg + 1'b1;
        if (({1'b0, src_col_reg} + 1'b1) >= {1'b0, sw})
        begin
            src_col_next = '0;
            dst_col_next = '0;
            col_end_next = qw;
            col_rem_next = rw;
            src_row_next = row_inc;
            if (row_hit)
            begin
                if ((WY'(dst_row_reg) + 1'b1) >= WY'(th))
                begin
                    dst_row_next = '0;
                    row_end_next = qh;
                    row_rem_next = rh;
                end
                else
                begin
                    dst_row_next = dst_row_reg + 1'b1;
                    if (row_sum >= {1'b0, th})
                    begin
                        row_rem_next = RW'(row_sum - {1'b0, th});
                        row_end_next = row_end_reg + qh + 1'b1;
                    end
                    else
                    begin
                        row_rem_next = RW'(row_sum);
                        row_end_next = row_end_reg + qh;
                    end
                end
            end
            if (({1'b0, src_row_reg} + 1'b1) >= {1'b0, sh})
            begin
                src_row_next = '0;
                dst_row_next = '0;
                row_end_next = qh;
                row_rem_next = rh;
            end
        end
    end

    always_comb
    begin
        acc.blue  = rdata.blue + SUM_W'(pix_b_reg);
        acc.green = rdata.green + SUM_W'(pix_g_reg);
        acc.red   = rdata.red + SUM_W'(pix_r_reg);
        acc.count = rdata.count + 1'b1;
        we    = 1'b0;
        waddr = col_reg;
        wdata = acc;
        if (state_reg == ST_INIT && !clr_done_reg)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (state_reg == ST_RMW)
        begin
            we = 1'b1;
            if (emit_reg)
                wdata = '0;
        end
    end

    bad_sum_ram #(.DEPTH(MAX_WIDTH), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(dst_col_reg), .rdata(rdata)
    );

    assign div_start = (state_reg == ST_RMW) && emit_reg;

    bad_divider #(.NW(SUM_W), .DW(CNT_W)) u_div_b (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc.blue),
        .divisor(acc.count), .done(div_done_b), .quotient(quo_b), .remainder(rem_b)
    );

    bad_divider #(.NW(SUM_W), .DW(CNT_W)) u_div_g (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc.green),
        .divisor(acc.count), .done(div_done_g), .quotient(quo_g), .remainder(rem_g)
    );

    bad_divider #(.NW(SUM_W), .DW(CNT_W)) u_div_r (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc.red),
        .divisor(acc.count), .done(div_done_r), .quotient(quo_r), .remainder(rem_r)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clr_done_reg && w_done_reg && h_done_reg && !setup_start_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_RMW;
            end
            ST_RMW:
            begin
                state_next = emit_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done_b && div_done_g && div_done_r)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (cfg_ok)
            state_next = ST_INIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            src_w_reg       <= 13'd4096;
            src_h_reg       <= 13'd4096;
            dst_w_reg       <= 13'd4096;
            dst_h_reg       <= 13'd4096;
            setup_start_reg <= 1'b1;
            w_done_reg      <= 1'b0;
            h_done_reg      <= 1'b0;
            clr_done_reg    <= 1'b0;
            clr_reg         <= '0;
            src_col_reg     <= '0;
            src_row_reg     <= '0;
            dst_col_reg     <= '0;
            dst_row_reg     <= '0;
            col_end_reg     <= '0;
            col_rem_reg     <= '0;
            row_end_reg     <= '0;
            row_rem_reg     <= '0;
            emit_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            setup_start_reg <= 1'b0;
            if (state_reg == ST_HOLD && state_next == ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_ok)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                    REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                    REG_TARGET_WIDTH:  dst_w_reg <= cfg_data;
                    REG_TARGET_HEIGHT: dst_h_reg <= cfg_data;
                    default:           src_w_reg <= src_w_reg;
                endcase
                setup_start_reg <= 1'b1;
                w_done_reg      <= 1'b0;
                h_done_reg      <= 1'b0;
                clr_done_reg    <= 1'b0;
                clr_reg         <= '0;
            end
            else if (state_reg == ST_INIT)
            begin
                if (dw_done)
                    w_done_reg <= 1'b1;
                if (dh_done)
                    h_done_reg <= 1'b1;
                if (!clr_done_reg)
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(MAX_WIDTH - 1))
                        clr_done_reg <= 1'b1;
                end
                src_col_reg <= '0;
                src_row_reg <= '0;
                dst_col_reg <= '0;
                dst_row_reg <= '0;
                col_end_reg <= qw;
                col_rem_reg <= rw;
                row_end_reg <= qh;
                row_rem_reg <= rh;
            end
            else if (accept)
            begin
                src_col_reg <= src_col_next;
                src_row_reg <= src_row_next;
                dst_col_reg <= dst_col_next;
                dst_row_reg <= dst_row_next;
                col_end_reg <= col_end_next;
                col_rem_reg <= col_rem_next;
                row_end_reg <= row_end_next;
                row_rem_reg <= row_rem_next;
                emit_reg    <= col_hit && row_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_b_reg <= s_axis_tdata[7:0];
            pix_g_reg <= s_axis_tdata[15:8];
            pix_r_reg <= s_axis_tdata[23:16];
            col_reg   <= dst_col_reg;
            row_reg   <= dst_row_reg;
            last_reg  <= ((WX'(dst_col_reg) + 1'b1) >= WX'(tw))
                      && ((WY'(dst_row_reg) + 1'b1) >= WY'(th));
        end
        if (div_start)
            zero_cnt_reg <= (acc.count == '0);
        if (state_reg == ST_HOLD && state_next == ST_IDLE)
        begin
            out_data_reg <= {POS_W'(row_reg), POS_W'(col_reg), ALPHA_OPAQUE,
                             zero_cnt_reg ? 8'd0 : quo_r[7:0],
                             zero_cnt_reg ? 8'd0 : quo_g[7:0],
                             zero_cnt_reg ? 8'd0 : quo_b[7:0]};
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### design/bad_checker.sv
// ----------------------------------------------------------------------------
// Box average downscaler port checker
// Concurrent checks on the core's ports, bound into the core module.
// ----------------------------------------------------------------------------
module bad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    import bad_pkg::*;

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:24] == ALPHA_OPAQUE)
        else $error("alpha not opaque");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled transfer changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("transfer taken while busy");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !s_axis_tready)
        else $error("ready during restart");

endmodule

bind box_average_downscaler_core bad_checker u_bad_checker (
    .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

### bench/box_average_downscaler_core_tb.sv
// ----------------------------------------------------------------------------
// Box average downscaler core testbench
// Streams source pixels through the core under several image and target
// sizes, mirrors the box averaging in a behavioral predictor and compares
// every output transfer field by field, with random gaps on both streams.
// ----------------------------------------------------------------------------
module box_average_downscaler_core_tb;

    import bad_pkg::*;

    localparam int MAX_W      = 4096;
    localparam int MAX_H      = 4096;
    localparam int DRAIN_WAIT = 80;
    localparam int STALL_LIMIT = 30000;
    localparam int PIXEL_GOAL = 1600;

    typedef struct {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
    } box_pixel_t;

    typedef struct {
        bit          is_cfg;
        reg_index_t  index;
        int          value;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        bit          typed;
    } script_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [55:0]      m_axis_tdata;
    logic             m_axis_tlast;

    box_average_downscaler_core #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mirror of the core state
    int unsigned src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    int unsigned sw, sh, tw, th;
    int unsigned blue_acc [MAX_W];
    int unsigned green_acc [MAX_W];
    int unsigned red_acc [MAX_W];
    int unsigned pixel_cnt [MAX_W];
    int unsigned src_col, src_row, dst_col, dst_row, col_end, row_end;

    box_pixel_t box_queue [$];
    box_pixel_t typed_box;
    bit         typed_pending = 1'b0;
    int         errors = 0;
    int         idle_cycles = 0;
    int         pixels_sent = 0;
    bit         ready_quiet = 1'b0;
    int         ready_hold = 0;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned box_edge(int unsigned d, int unsigned src,
                                             int unsigned dst);
        longint unsigned p;
        p = (longint'(d) + 1) * longint'(src) / longint'(dst);
        return int'(p);
    endfunction

    task automatic restart_frame();
        sw = clamp_size(src_w_reg, MAX_W);
        sh = clamp_size(src_h_reg, MAX_H);
        tw = clamp_size(dst_w_reg, sw);
        th = clamp_size(dst_h_reg, sh);
        for (int i = 0; i < MAX_W; i++)
        begin
            blue_acc[i] = 0;
            green_acc[i] = 0;
            red_acc[i] = 0;
            pixel_cnt[i] = 0;
        end
        src_col = 0;
        src_row = 0;
        dst_col = 0;
        dst_row = 0;
        col_end = box_edge(0, sw, tw);
        row_end = box_edge(0, sh, th);
    endtask

    task automatic write_register_mirror(logic [1:0] index, logic [CFG_W-1:0] value);
        case (reg_index_t'(index))
            REG_SOURCE_WIDTH:  src_w_reg = value;
            REG_SOURCE_HEIGHT: src_h_reg = value;
            REG_TARGET_WIDTH:  dst_w_reg = value;
            REG_TARGET_HEIGHT: dst_h_reg = value;
        endcase
        restart_frame();
    endtask

    task automatic accumulate_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                    output bit closed, output box_pixel_t res);
        int unsigned col;
        int unsigned c;
        col = (dst_col < MAX_W) ? dst_col : 0;
        closed = 1'b0;
        res = '{default: '0};
        blue_acc[col] += b;
        green_acc[col] += g;
        red_acc[col] += r;
        pixel_cnt[col] = (pixel_cnt[col] + 1) & 32'h1FF_FFFF;
        if (src_col + 1 >= col_end)
        begin
            if (src_row + 1 >= row_end)
            begin
                c = pixel_cnt[col];
                res.blue = (c != 0) ? 8'(blue_acc[col] / c) : 8'd0;
                res.green = (c != 0) ? 8'(green_acc[col] / c) : 8'd0;
                res.red = (c != 0) ? 8'(red_acc[col] / c) : 8'd0;
                res.alpha = ALPHA_OPAQUE;
                res.column = 12'(col);
                res.row = 12'(dst_row);
                res.last = (col + 1 >= tw) && (dst_row + 1 >= th);
                blue_acc[col] = 0;
                green_acc[col] = 0;
                red_acc[col] = 0;
                pixel_cnt[col] = 0;
                closed = 1'b1;
            end
            dst_col = col + 1;
            if (dst_col >= tw)
                dst_col = 0;
            col_end = box_edge(dst_col, sw, tw);
        end
        src_col++;
        if (src_col >= sw)
        begin
            src_col = 0;
            dst_col = 0;
            col_end = box_edge(0, sw, tw);
            src_row++;
            if (src_row >= row_end)
            begin
                dst_row++;
                if (dst_row >= th)
                    dst_row = 0;
            end
            if (src_row >= sh)
            begin
                src_row = 0;
                dst_row = 0;
            end
            row_end = box_edge(dst_row, sh, th);
        end
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
        errors++;
    endtask

    // sample both streams and the register port
    always @(posedge clk)
    begin
        box_pixel_t got;
        box_pixel_t want;
        box_pixel_t res;
        bit         closed;
        if (rst_n)
        begin
            if (cfg_write || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.blue = m_axis_tdata[7:0];
                got.green = m_axis_tdata[15:8];
                got.red = m_axis_tdata[23:16];
                got.alpha = m_axis_tdata[31:24];
                got.column = m_axis_tdata[43:32];
                got.row = m_axis_tdata[55:44];
                got.last = m_axis_tlast;
                if (box_queue.size() == 0)
                begin
                    report_mismatch("unexpected output transfer", 1, 0);
                end
                else
                begin
                    want = box_queue.pop_front();
                    if (got.blue !== want.blue)
                        report_mismatch("out_blue", got.blue, want.blue);
                    if (got.green !== want.green)
                        report_mismatch("out_green", got.green, want.green);
                    if (got.red !== want.red)
                        report_mismatch("out_red", got.red, want.red);
                    if (got.alpha !== want.alpha)
                        report_mismatch("out_alpha", got.alpha, want.alpha);
                    if (got.column !== want.column)
                        report_mismatch("out_column", got.column, want.column);
                    if (got.row !== want.row)
                        report_mismatch("out_row", got.row, want.row);
                    if (got.last !== want.last)
                        report_mismatch("frame_last", got.last, want.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                accumulate_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                 s_axis_tdata[23:16], closed, res);
                if (typed_pending)
                    box_queue.push_back(typed_box);
                else if (closed)
                    box_queue.push_back(res);
            end
            if (cfg_write)
                write_register_mirror(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output backpressure: mostly short stalls, a few long, some quiet stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready = 1'b0;
        else if (ready_hold > 0)
        begin
            m_axis_tready = 1'b0;
            ready_hold--;
        end
        else
        begin
            m_axis_tready = 1'b1;
            if (!ready_quiet && $urandom_range(0, 3) == 0)
                ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 3);
        end
    end

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return 0;
        if (sel < 19)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {r, g, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (box_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_register(reg_index_t index, int value);
        wait_drained();
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data = CFG_W'(value);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    script_row_t script [$];

    task automatic add_cfg(reg_index_t index, int value);
        script.push_back('{1'b1, index, value, 8'h00, 8'h00, 8'h00, 1'b0});
    endtask

    task automatic add_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit typed);
        script.push_back('{1'b0, REG_SOURCE_WIDTH, 0, b, g, r, typed});
    endtask

    initial
    begin
        int sw_pick, sh_pick, tw_pick, th_pick, count;
        bit pressure_done;
        src_w_reg = 4096;
        src_h_reg = 4096;
        dst_w_reg = 4096;
        dst_h_reg = 4096;
        restart_frame();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // one pixel boxes: every output is its own input
        add_cfg(REG_SOURCE_WIDTH, 1);
        add_cfg(REG_SOURCE_HEIGHT, 1);
        add_cfg(REG_TARGET_WIDTH, 1);
        add_cfg(REG_TARGET_HEIGHT, 1);
        add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'hA5, 8'h5A, 8'h0F, 1'b1);
        add_pixel(8'h01, 8'h80, 8'hFE, 1'b1);
        // zero sizes are taken as one
        add_cfg(REG_SOURCE_WIDTH, 0);
        add_cfg(REG_TARGET_HEIGHT, 0);
        add_pixel(8'h7F, 8'h00, 8'hFF, 1'b1);
        // upscale request clamps to source size
        add_cfg(REG_SOURCE_WIDTH, 3);
        add_cfg(REG_SOURCE_HEIGHT, 2);
        add_cfg(REG_TARGET_WIDTH, 8191);
        add_cfg(REG_TARGET_HEIGHT, 4096);
        repeat (6) add_pixel(random_channel(), random_channel(), random_channel(), 1'b0);
        // uneven boxes, frame wrap
        add_cfg(REG_SOURCE_WIDTH, 5);
        add_cfg(REG_TARGET_WIDTH, 2);
        add_cfg(REG_TARGET_HEIGHT, 1);
        repeat (12) add_pixel(random_channel(), random_channel(), random_channel(), 1'b0);
        // oversized source, partial row only
        add_cfg(REG_SOURCE_WIDTH, 8191);
        add_cfg(REG_SOURCE_HEIGHT, 8191);
        add_cfg(REG_TARGET_WIDTH, 2);
        repeat (5) add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_register(script[i].index, script[i].value);
            else
            begin
                typed_pending = script[i].typed;
                typed_box = '{script[i].blue, script[i].green, script[i].red,
                              ALPHA_OPAQUE, 12'd0, 12'd0, 1'b1};
                send_pixel(script[i].blue, script[i].green, script[i].red, 1'b1);
            end
        end
        typed_pending = 1'b0;

        pressure_done = 1'b0;
        while (pixels_sent < PIXEL_GOAL)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                sw_pick = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(30, 8191);
                sh_pick = $urandom_range(1, 3);
            end
            else
            begin
                sw_pick = $urandom_range(1, 16);
                sh_pick = $urandom_range(1, 8);
            end
            tw_pick = $urandom_range(0, 4) == 0 ? $urandom_range(0, 8191)
                                                : $urandom_range(1, (sw_pick > 16) ? 16
                                                                 : sw_pick + 1);
            th_pick = $urandom_range(0, 4) == 0 ? $urandom_range(0, 8191)
                                                : $urandom_range(1, sh_pick + 1);
            write_register(REG_SOURCE_WIDTH, sw_pick);
            write_register(REG_SOURCE_HEIGHT, sh_pick);
            write_register(REG_TARGET_WIDTH, tw_pick);
            write_register(REG_TARGET_HEIGHT, th_pick);
            ready_quiet = ($urandom_range(0, 3) == 0);
            if (sw < 32)
                count = sw * sh * $urandom_range(1, 3) + $urandom_range(0, sw);
            else
                count = $urandom_range(5, 60);
            for (int k = 0; k < count; k++)
            begin
                if (!pressure_done && k == count / 2)
                begin
                    wait_drained();
                    pressure_done = 1'b1;
                end
                send_pixel(random_channel(), random_channel(), random_channel(),
                           !ready_quiet);
            end
        end

        ready_quiet = 1'b0;
        wait_drained();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
